### hw/rtl/bols_pkg.sv
package bols_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CONTAINS   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd5;

    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic del;
        logic load_back;
    } cell_ctrl_t;

endpackage

### hw/rtl/bols_if.sv
interface bols_req_if;
    import bols_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface bols_rsp_if;
    import bols_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_out;
    logic               found;
    logic               error;
    modport source (output valid, output value_out, output found, output error, input ready);
    modport sink (input valid, input value_out, input found, input error, output ready);
endinterface

interface bols_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/bols_cell.sv
module bols_cell (
    input  logic                             clk,
    input  bols_pkg::cell_ctrl_t             ctrl,
    input  logic                             in_use,
    input  logic                             is_back,
    input  logic [bols_pkg::DATA_WIDTH-1:0]  key,
    input  logic [bols_pkg::DATA_WIDTH-1:0]  left_data,
    input  logic [bols_pkg::DATA_WIDTH-1:0]  right_data,
    input  logic                             hit_in,
    output logic                             hit_out,
    output logic [bols_pkg::DATA_WIDTH-1:0]  data
);
    import bols_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    assign hit_out = hit_in | (in_use && (data_reg == key));
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_r)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_l || (ctrl.del && hit_out))
        begin
            data_next = right_data;
        end
        else if (ctrl.load_back && is_back)
        begin
            data_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### hw/rtl/bounded_ordered_list_store_unit.sv
// flow: a request beat is captured, then executed on the cell chain once the output register is free or being taken
// one operation at a time: a new request is taken only after the previous one has executed
// a response may wait in the output register while the next request is taken
// reset: asynchronous active-low, list emptied, list_valid set to one
// entry storage has no reset, entries are read only after being written
module bounded_ordered_list_store_unit (
    input  logic             clk,
    input  logic             rst_n,
    bols_req_if.sink         req,
    bols_rsp_if.source       rsp,
    bols_cfg_if.sink         cfg
);
    import bols_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic                  list_valid_reg;
    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    value_out_reg;
    logic                  found_reg;
    logic                  error_reg;

    logic                  in_fire;
    logic                  exec_fire;
    logic                  full;
    logic                  empty;
    logic                  hit;
    logic [IDX_W-1:0]      last_idx;
    logic [VALUE_W-1:0]    vout;
    logic                  found_v;
    logic                  err_v;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]        hit_chain;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;

    assign full     = (occ_reg == CNT_W'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign hit      = hit_chain[DEPTH];
    assign last_idx = IDX_W'(occ_reg - CNT_W'(1));

    assign hit_chain[0] = 1'b0;

    // cell chain, front of the list at cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = key_reg;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        bols_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .in_use     (occ_reg > CNT_W'(i)),
            .is_back    (occ_reg == CNT_W'(i)),
            .key        (key_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        ctrl     = '0;
        occ_next = occ_reg;
        vout     = '0;
        found_v  = 1'b0;
        err_v    = 1'b0;
        unique case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    err_v = 1'b1;
                end
                else
                begin
                    ctrl.shift_r   = (op_reg == OP_PUSH_FRONT);
                    ctrl.load_back = (op_reg == OP_PUSH_BACK);
                    occ_next       = occ_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    err_v = 1'b1;
                end
                else
                begin
                    vout         = VALUE_W'(cell_data[0]);
                    ctrl.shift_l = 1'b1;
                    occ_next     = occ_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    err_v = 1'b1;
                end
                else
                begin
                    vout     = VALUE_W'(cell_data[last_idx]);
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            OP_CONTAINS:
            begin
                if (!list_valid_reg)
                begin
                    err_v = 1'b1;
                end
                else
                begin
                    found_v = hit;
                end
            end
            OP_DELETE:
            begin
                if (!list_valid_reg || !hit)
                begin
                    err_v = 1'b1;
                end
                else
                begin
                    ctrl.del = 1'b1;
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (!exec_fire)
        begin
            ctrl     = '0;
            occ_next = occ_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            list_valid_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg.valid && cfg.ready)
            begin
                list_valid_reg <= cfg.data;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= req.opcode;
            key_reg <= DATA_WIDTH'(req.value);
        end
        if (exec_fire)
        begin
            value_out_reg <= vout;
            found_reg     <= found_v;
            error_reg     <= err_v;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.found     = found_reg;
    assign rsp.error     = error_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + CNT_W'(1))
        || (occ_reg == $past(occ_reg) - CNT_W'(1)))
        else $error("list count moved by more than one");

    a_occ_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(occ_reg))
        else $error("list count changed outside an operation");

    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response beat without an operation");

    a_req_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("request beat not followed by execution");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import bols_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_OPS   = 60;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic               found;
        logic               error;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    bols_req_if req_ch ();
    bols_rsp_if rsp_ch ();
    bols_cfg_if cfg_ch ();

    bounded_ordered_list_store_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted list contents, front first
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    int                    shadow_len;
    bit                    shadow_valid;

    list_rsp_t pending_rsp [$];
    logic [VALUE_W-1:0] key_pool [8];

    int  mismatches;
    int  ops_sent;
    int  rsp_checked;
    int  cfg_writes;
    int  cycles;
    bit  req_idle_en;
    bit  rsp_idle_en;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("bounded_ordered_list_store_unit: mismatch");
            $finish;
        end
    end

    function automatic list_rsp_t apply_list_op(input logic [OPCODE_W-1:0] op,
                                                input logic [VALUE_W-1:0] key);
        list_rsp_t r;
        int        hit;
        r   = '0;
        hit = -1;
        if (op == OP_CONTAINS || op == OP_DELETE)
        begin
            for (int i = 0; i < shadow_len; i++)
            begin
                if (hit < 0 && shadow_words[i] == key[DATA_WIDTH-1:0])
                    hit = i;
            end
        end
        case (op)
            OP_PUSH_FRONT:
            begin
                if (shadow_len >= DEPTH)
                    r.error = 1'b1;
                else
                begin
                    for (int i = shadow_len; i > 0; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[0] = key[DATA_WIDTH-1:0];
                    shadow_len++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (shadow_len >= DEPTH)
                    r.error = 1'b1;
                else
                begin
                    shadow_words[shadow_len] = key[DATA_WIDTH-1:0];
                    shadow_len++;
                end
            end
            OP_POP_FRONT:
            begin
                if (shadow_len == 0)
                    r.error = 1'b1;
                else
                begin
                    r.value_out = shadow_words[0];
                    for (int i = 1; i < shadow_len; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_len--;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_len == 0)
                    r.error = 1'b1;
                else
                begin
                    shadow_len--;
                    r.value_out = shadow_words[shadow_len];
                end
            end
            OP_CONTAINS:
            begin
                if (!shadow_valid)
                    r.error = 1'b1;
                else
                    r.found = (hit >= 0);
            end
            OP_DELETE:
            begin
                if (!shadow_valid || hit < 0)
                    r.error = 1'b1;
                else
                begin
                    for (int i = hit + 1; i < shadow_len; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_len--;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] %s wrong: expected %h, got %h", $time, field, want, got);
    endtask

    // leaves valid high after the beat; req_quiet lowers it when no item follows
    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] key);
        int gap;
        bit took;
        gap = req_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= key;
        do
        begin
            @(negedge clk);
            took = req_ch.ready;
            if (took)
                pending_rsp.push_back(apply_list_op(op, key));
            @(posedge clk);
        end
        while (!took);
        ops_sent++;
    endtask

    task automatic req_quiet();
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        req_quiet();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_list_valid(input bit v);
        bit took;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_ch.valid <= 1'b0;
        shadow_valid = v;
        cfg_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        if (r < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        case ($urandom_range(0, 3))
            0: return OP_POP_FRONT;
            1: return OP_POP_BACK;
            2: return OP_CONTAINS;
            default: return OP_DELETE;
        endcase
    endfunction

    task automatic test_empty_list();
        send_op(OP_POP_FRONT, 32'h0000_0000);
        send_op(OP_POP_BACK, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 32'h0000_0000);
        send_op(OP_SPARE_LO, 32'hAAAA_AAAA);
        send_op(OP_SPARE_HI, 32'h5555_5555);
        drain();
    endtask

    task automatic test_full_list();
        logic [VALUE_W-1:0] w;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0: w = 32'h0000_0000;
                1: w = 32'hFFFF_FFFF;
                2: w = 32'h8000_0000;
                3: w = 32'h0000_0001;
                4: w = 32'hAAAA_AAAA;
                5: w = 32'h5555_5555;
                default: w = $urandom();
            endcase
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, w);
        end
        send_op(OP_PUSH_FRONT, 32'h1234_5678);
        send_op(OP_PUSH_BACK, 32'h8765_4321);
        send_op(OP_CONTAINS, 32'hFFFF_FFFF);
        send_op(OP_CONTAINS, 32'hDEAD_BEEF);
        send_op(OP_DELETE, 32'h0000_0000);
        send_op(OP_DELETE, 32'hDEAD_BEEF);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        drain();
    endtask

    task automatic test_invalid_list();
        set_list_valid(1'b0);
        send_op(OP_CONTAINS, 32'h8000_0000);
        send_op(OP_DELETE, 32'h8000_0000);
        drain();
        set_list_valid(1'b1);
    endtask

    task automatic test_random_ops();
        int push_pct;
        logic [VALUE_W-1:0] k;
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_list_valid((p == 2 || p == 4) ? 1'b0 : 1'b1);
            req_idle_en = (p != 3);
            rsp_idle_en = (p != 3 && p != 5);
            case (p)
                0: push_pct = 25;
                1: push_pct = 70;
                2: push_pct = 50;
                3: push_pct = 60;
                4: push_pct = 40;
                default: push_pct = 50;
            endcase
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // push then look up and remove the same word
                    k = pick_key();
                    send_op(OP_PUSH_BACK, k);
                    send_op(OP_CONTAINS, k);
                    send_op(OP_DELETE, k);
                end
                else
                    send_op(pick_op(push_pct), pick_key());
            end
        end
        drain();
        req_idle_en = 1'b1;
        rsp_idle_en = 1'b1;
    endtask

    // response side: random stalls while rsp_idle_en is set, each beat checked against the oldest prediction
    initial
    begin
        int        stall;
        bit        took;
        list_rsp_t want;
        list_rsp_t got;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = rsp_idle_en ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = rsp_ch.valid;
                if (took)
                begin
                    got.value_out = rsp_ch.value_out;
                    got.found     = rsp_ch.found;
                    got.error     = rsp_ch.error;
                    if (pending_rsp.size() == 0)
                        report_mismatch("unexpected beat", '0, got.value_out);
                    else
                    begin
                        want = pending_rsp.pop_front();
                        if (got.value_out !== want.value_out)
                            report_mismatch("value_out", want.value_out, got.value_out);
                        if (got.found !== want.found)
                            report_mismatch("found", VALUE_W'(want.found),
                                            VALUE_W'(got.found));
                        if (got.error !== want.error)
                            report_mismatch("error", VALUE_W'(want.error),
                                            VALUE_W'(got.error));
                    end
                    rsp_checked++;
                end
                @(posedge clk);
            end
            while (!took);
        end
    end

    initial
    begin
        mismatches   = 0;
        ops_sent     = 0;
        rsp_checked  = 0;
        cfg_writes   = 0;
        req_idle_en  = 1'b1;
        rsp_idle_en  = 1'b1;
        shadow_len   = 0;
        shadow_valid = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            shadow_words[i] = '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = $urandom();

        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_PUSH_FRONT;
        req_ch.value  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_full_list();
        test_invalid_list();
        test_random_ops();
        drain();

        if (pending_rsp.size() != 0)
            report_mismatch("missing beats", VALUE_W'(pending_rsp.size()), '0);
        $display("covered %0d operations on empty, full and partly filled lists", ops_sent);
        $display("checked %0d responses across %0d list_valid writes", rsp_checked,
                 cfg_writes);
        if (mismatches == 0)
            $display("bounded_ordered_list_store_unit: match");
        else
            $display("bounded_ordered_list_store_unit: mismatch");
        $finish;
    end

endmodule
